// ===== rtl/olqf_pkg.sv =====
// ----------------------------------------------------------------------------
// olqf_pkg
// Types, constants and fixed-point helpers shared by the online line and
// quadratic fit unit.
// ----------------------------------------------------------------------------
package olqf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int RATE_W   = 25;
  localparam int ACC_W    = 41;
  localparam int PROD_W   = 64;
  localparam int SAMPLE_FRAC = 12;
  localparam int COEF_FRAC   = 24;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [RATE_W-1:0]          rate_t;

  localparam rate_t RATE_RESET = 25'd1677722;
  localparam coef_t COEF_ZERO  = 32'sd0;
  localparam coef_t COEF_ONE   = 32'sd16777216;
  localparam coef_t COEF_MAX   = 32'sh7fffffff;
  localparam coef_t COEF_MIN   = 32'sh80000000;
  localparam prod_t HALF_SAMPLE = 64'sd2048;
  localparam prod_t HALF_COEF   = 64'sd8388608;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_IDLE,
    MUL_XX,
    MUL_SLOPE_X,
    MUL_SQUARE_X2,
    MUL_LINEAR_X,
    MUL_RATE_E1,
    MUL_RATE_E2,
    MUL_G1_X,
    MUL_G2_X2,
    MUL_G2_X
  } mul_sel_t;

  // what the datapath does with the registered product
  typedef enum logic [3:0] {
    WB_NONE,
    WB_X2,
    WB_ACC1,
    WB_ACC2_E1,
    WB_ACC2_ADD,
    WB_G1_E2,
    WB_OFFSET,
    WB_G2,
    WB_SLOPE_CONST,
    WB_SQUARE,
    WB_LINEAR
  } wb_sel_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    coef_t line_error;
    coef_t quad_error;
    coef_t line_slope;
    coef_t line_offset;
    coef_t quad_square;
    coef_t quad_linear;
    coef_t quad_const;
  } res_t;

  function automatic coef_t sat_coef(input acc_t v);
    coef_t r;
    if (v[ACC_W-1:COEF_W-1] == '0 || v[ACC_W-1:COEF_W-1] == '1) begin
      r = v[COEF_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = COEF_MIN;
    end else begin
      r = COEF_MAX;
    end
    return r;
  endfunction

  // round half up, drop sample fraction bits
  function automatic acc_t rnd_sample(input prod_t v);
    prod_t t;
    t = (v + HALF_SAMPLE) >>> SAMPLE_FRAC;
    return t[ACC_W-1:0];
  endfunction

  // round half up, drop coefficient fraction bits
  function automatic acc_t rnd_coef(input prod_t v);
    prod_t t;
    t = (v + HALF_COEF) >>> COEF_FRAC;
    return t[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/olqf_if.sv =====
// ----------------------------------------------------------------------------
// olqf channel interfaces
// Valid/ready channels for samples, results and the rate register write.
// ----------------------------------------------------------------------------
interface olqf_in_if;
  import olqf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_x;
  sample_t sample_y;
  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface olqf_out_if;
  import olqf_pkg::*;
  logic  valid;
  logic  ready;
  coef_t line_error;
  coef_t quad_error;
  coef_t line_slope_out;
  coef_t line_offset_out;
  coef_t quad_square_out;
  coef_t quad_linear_out;
  coef_t quad_const_out;
  modport source (
    output valid, output line_error, output quad_error, output line_slope_out,
    output line_offset_out, output quad_square_out, output quad_linear_out,
    output quad_const_out, input ready
  );
  modport sink (
    input valid, input line_error, input quad_error, input line_slope_out,
    input line_offset_out, input quad_square_out, input quad_linear_out,
    input quad_const_out, output ready
  );
endinterface

interface olqf_cfg_if;
  import olqf_pkg::*;
  logic  valid;
  logic  ready;
  rate_t learning_rate;
  modport source (output valid, output learning_rate, input ready);
  modport sink   (input valid, input learning_rate, output ready);
endinterface

// ===== rtl/olqf_dp.sv =====
// ----------------------------------------------------------------------------
// olqf_dp
// Datapath: shared 32x32 multiplier with registered product, coefficient
// state, error and gradient registers, and the result register.
// ----------------------------------------------------------------------------
module olqf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  olqf_pkg::cmd_t   cmd,
  input  olqf_pkg::sample_t in_x,
  input  olqf_pkg::sample_t in_y,
  input  logic             cfg_wr,
  input  olqf_pkg::rate_t  cfg_rate,
  output olqf_pkg::res_t   res
);
  import olqf_pkg::*;

  rate_t   rate_r, rate_nxt;
  coef_t   line_slope_r, line_slope_nxt;
  coef_t   line_offset_r, line_offset_nxt;
  coef_t   quad_square_r, quad_square_nxt;
  coef_t   quad_linear_r, quad_linear_nxt;
  coef_t   quad_const_r, quad_const_nxt;

  sample_t x_r, x_nxt;
  sample_t y_r, y_nxt;
  coef_t   x2_r, x2_nxt;
  acc_t    acc1_r, acc1_nxt;
  acc_t    acc2_r, acc2_nxt;
  coef_t   e1_r, e1_nxt;
  coef_t   e2_r, e2_nxt;
  coef_t   g1_r, g1_nxt;
  coef_t   g2_r, g2_nxt;
  prod_t   prod_r, prod_nxt;
  res_t    res_r, res_nxt;

  coef_t   op_a, op_b, x_ext;
  acc_t    y24;

  assign x_ext = coef_t'(x_r);
  assign y24   = acc_t'(y_r) <<< (COEF_FRAC - SAMPLE_FRAC);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_XX:        begin op_a = x_ext;         op_b = x_ext; end
      MUL_SLOPE_X:   begin op_a = line_slope_r;  op_b = x_ext; end
      MUL_SQUARE_X2: begin op_a = quad_square_r; op_b = x2_r;  end
      MUL_LINEAR_X:  begin op_a = quad_linear_r; op_b = x_ext; end
      MUL_RATE_E1:   begin op_a = coef_t'(rate_r); op_b = e1_r; end
      MUL_RATE_E2:   begin op_a = coef_t'(rate_r); op_b = e2_r; end
      MUL_G1_X:      begin op_a = g1_r;          op_b = x_ext; end
      MUL_G2_X2:     begin op_a = g2_r;          op_b = x2_r;  end
      MUL_G2_X:      begin op_a = g2_r;          op_b = x_ext; end
      default:       begin op_a = COEF_ZERO;     op_b = COEF_ZERO; end
    endcase
    prod_nxt = prod_t'(op_a) * prod_t'(op_b);
  end

  always_comb begin
    x_nxt           = cmd.capture ? in_x : x_r;
    y_nxt           = cmd.capture ? in_y : y_r;
    rate_nxt        = cfg_wr ? cfg_rate : rate_r;
    x2_nxt          = x2_r;
    acc1_nxt        = acc1_r;
    acc2_nxt        = acc2_r;
    e1_nxt          = e1_r;
    e2_nxt          = e2_r;
    g1_nxt          = g1_r;
    g2_nxt          = g2_r;
    line_slope_nxt  = line_slope_r;
    line_offset_nxt = line_offset_r;
    quad_square_nxt = quad_square_r;
    quad_linear_nxt = quad_linear_r;
    quad_const_nxt  = quad_const_r;
    unique case (cmd.wb_sel)
      WB_NONE: ;
      WB_X2:   x2_nxt = prod_r[COEF_W-1:0];
      WB_ACC1: acc1_nxt = rnd_sample(prod_r) + acc_t'(line_offset_r);
      WB_ACC2_E1: begin
        acc2_nxt = rnd_coef(prod_r) + acc_t'(quad_const_r);
        e1_nxt   = sat_coef(y24 - acc1_r);
      end
      WB_ACC2_ADD: acc2_nxt = acc2_r + rnd_sample(prod_r);
      WB_G1_E2: begin
        // gradient keeps the factor of two
        g1_nxt = sat_coef(rnd_coef(prod_r <<< 1));
        e2_nxt = sat_coef(y24 - acc2_r);
      end
      WB_OFFSET: line_offset_nxt = sat_coef(acc_t'(line_offset_r) + acc_t'(g1_r));
      WB_G2:     g2_nxt = sat_coef(rnd_coef(prod_r <<< 1));
      WB_SLOPE_CONST: begin
        line_slope_nxt = sat_coef(acc_t'(line_slope_r) + rnd_sample(prod_r));
        quad_const_nxt = sat_coef(acc_t'(quad_const_r) + acc_t'(g2_r));
      end
      WB_SQUARE: quad_square_nxt = sat_coef(acc_t'(quad_square_r) + rnd_coef(prod_r));
      WB_LINEAR: quad_linear_nxt = sat_coef(acc_t'(quad_linear_r) + rnd_sample(prod_r));
      default: ;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.out_load) begin
      res_nxt.line_error  = e1_r;
      res_nxt.quad_error  = e2_r;
      res_nxt.line_slope  = line_slope_r;
      res_nxt.line_offset = line_offset_r;
      res_nxt.quad_square = quad_square_r;
      res_nxt.quad_linear = quad_linear_r;
      res_nxt.quad_const  = quad_const_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r        <= RATE_RESET;
      line_slope_r  <= COEF_ZERO;
      line_offset_r <= COEF_ZERO;
      quad_square_r <= COEF_ONE;
      quad_linear_r <= COEF_ONE;
      quad_const_r  <= COEF_ONE;
    end else begin
      rate_r        <= rate_nxt;
      line_slope_r  <= line_slope_nxt;
      line_offset_r <= line_offset_nxt;
      quad_square_r <= quad_square_nxt;
      quad_linear_r <= quad_linear_nxt;
      quad_const_r  <= quad_const_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    x2_r   <= x2_nxt;
    acc1_r <= acc1_nxt;
    acc2_r <= acc2_nxt;
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
    g1_r   <= g1_nxt;
    g2_r   <= g2_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/olqf_ctrl.sv =====
// ----------------------------------------------------------------------------
// olqf_ctrl
// Sequencer: steps one sample through the shared multiplier and the
// writeback ops, then hands the result to the output register.
// ----------------------------------------------------------------------------
module olqf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output olqf_pkg::cmd_t cmd
);
  import olqf_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_X2   = 13'b0000000000010,
    S_P1   = 13'b0000000000100,
    S_Q    = 13'b0000000001000,
    S_L    = 13'b0000000010000,
    S_G1   = 13'b0000000100000,
    S_E2   = 13'b0000001000000,
    S_G2   = 13'b0000010000000,
    S_U1   = 13'b0000100000000,
    S_U2   = 13'b0001000000000,
    S_U3   = 13'b0010000000000,
    S_U4   = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_full_r, out_full_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_full_r;
  assign slot_free = !out_full_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.mul_sel  = MUL_IDLE;
    cmd.wb_sel   = WB_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_X2;
      end
      S_X2: begin cmd.mul_sel = MUL_XX;        state_nxt = S_P1; end
      S_P1: begin
        cmd.mul_sel = MUL_SLOPE_X;   cmd.wb_sel = WB_X2;       state_nxt = S_Q;
      end
      S_Q: begin
        cmd.mul_sel = MUL_SQUARE_X2; cmd.wb_sel = WB_ACC1;     state_nxt = S_L;
      end
      S_L: begin
        cmd.mul_sel = MUL_LINEAR_X;  cmd.wb_sel = WB_ACC2_E1;  state_nxt = S_G1;
      end
      S_G1: begin
        cmd.mul_sel = MUL_RATE_E1;   cmd.wb_sel = WB_ACC2_ADD; state_nxt = S_E2;
      end
      S_E2: begin cmd.wb_sel = WB_G1_E2; state_nxt = S_G2; end
      S_G2: begin
        cmd.mul_sel = MUL_RATE_E2;   cmd.wb_sel = WB_OFFSET;   state_nxt = S_U1;
      end
      S_U1: begin
        cmd.mul_sel = MUL_G1_X;      cmd.wb_sel = WB_G2;       state_nxt = S_U2;
      end
      S_U2: begin
        cmd.mul_sel = MUL_G2_X2;     cmd.wb_sel = WB_SLOPE_CONST; state_nxt = S_U3;
      end
      S_U3: begin
        cmd.mul_sel = MUL_G2_X;      cmd.wb_sel = WB_SQUARE;   state_nxt = S_U4;
      end
      S_U4: begin cmd.wb_sel = WB_LINEAR; state_nxt = S_DONE; end
      S_DONE: begin
        // wait here until the output register can take the result
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_full_nxt = out_full_r;
    if (cmd.out_load) begin
      out_full_nxt = 1'b1;
    end else if (out_ready) begin
      out_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_full_r <= out_full_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_X2))
    else $error("accepted sample did not start the sequence");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_full_r || out_ready))
    else $error("result loaded over an untaken result");

  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_full_r && state_r == S_IDLE))
    else $error("result load did not mark output full and return to idle");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.capture)
    else $error("sample captured while a sample is in flight");
`endif

endmodule

// ===== rtl/online_lms_line_and_quadratic_fit_unit.sv =====
// ----------------------------------------------------------------------------
// online_lms_line_and_quadratic_fit_unit
// Online gradient-descent fit of a line and a quadratic, one sample at a time.
// ----------------------------------------------------------------------------
// channel    dir  payload                                        accepted when
// in_chan    in   sample_x, sample_y (Q4.12)                     valid & ready
// out_chan   out  two errors, five updated coefficients (Q8.24)  valid & ready
// cfg_chan   in   learning_rate (Q1.24, unsigned)                valid & ready
//
// The nine products of a sample go one after another through a single
// 32x32 multiplier with a registered product. in_ready is high only while
// no sample is in flight; a finished result waits in the output register
// while the next sample is taken.
// Synchronous active-low reset; coefficients return to their start values
// and learning_rate to 0.1. cfg_chan is always ready.
// ----------------------------------------------------------------------------
module online_lms_line_and_quadratic_fit_unit (
  input logic        clk,
  input logic        rst_n,
  olqf_in_if.sink    in_chan,
  olqf_out_if.source out_chan,
  olqf_cfg_if.sink   cfg_chan
);
  import olqf_pkg::*;

  cmd_t cmd;
  res_t res;

  assign cfg_chan.ready = 1'b1;

  olqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  olqf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_x     (in_chan.sample_x),
    .in_y     (in_chan.sample_y),
    .cfg_wr   (cfg_chan.valid),
    .cfg_rate (cfg_chan.learning_rate),
    .res      (res)
  );

  assign out_chan.line_error      = res.line_error;
  assign out_chan.quad_error      = res.quad_error;
  assign out_chan.line_slope_out  = res.line_slope;
  assign out_chan.line_offset_out = res.line_offset;
  assign out_chan.quad_square_out = res.quad_square;
  assign out_chan.quad_linear_out = res.quad_linear;
  assign out_chan.quad_const_out  = res.quad_const;

endmodule
